>>> rtl/core/uvs_pkg.sv
// shared types and constants of the uv sphere vertex generator
package uvs_pkg;

  localparam int unsigned IDX_W    = 11;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned COLOR_W  = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned ATAN_ENTRIES = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS      = 3'd0,
    REG_SLICE_COUNT = 3'd1,
    REG_STACK_COUNT = 3'd2,
    REG_NORTH_COLOR = 3'd3,
    REG_SOUTH_COLOR = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051119D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  localparam logic [31:0] CORDIC_X0 = 32'd652032874;

  typedef struct packed {
    logic [IDX_W-1:0] stack;
    logic [IDX_W-1:0] slice;
    logic             quad;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic [CNT_W-1:0]    slices;
    logic [CNT_W-1:0]    stacks;
    logic [COLOR_W-1:0]  north;
    logic [COLOR_W-1:0]  south;
  } cfg_t;

endpackage

>>> rtl/core/uvs_if.sv
// handshake channels of the uv sphere vertex generator
interface uvs_in_if;
  logic        valid;
  logic        ready;
  logic [10:0] stack_index;
  logic [10:0] slice_index;
  modport source (output valid, stack_index, slice_index, input ready);
  modport sink (input valid, stack_index, slice_index, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [14:0]        tex_s;
  logic [14:0]        tex_t;
  logic [63:0]        blend_color;
  logic [20:0]        vertex_number;
  logic               quad_valid;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t,
                  blend_color, vertex_number, quad_valid, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_s, tex_t,
                blend_color, vertex_number, quad_valid, output ready);
endinterface

>>> rtl/core/uvs_front.sv
// front end: index clamping, quad classification and the item queue
module uvs_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  uvs_in_if.sink                        in_i,
  input  logic [uvs_pkg::CNT_W-1:0]     slices_i,
  input  logic [uvs_pkg::CNT_W-1:0]     stacks_i,
  output uvs_pkg::queue_t               head_o,
  input  logic                          pop_i
);

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = 2;

  uvs_pkg::item_t     mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]     count_q;
  uvs_pkg::item_t     item;
  logic               push;

  always_comb begin
    item.stack = (in_i.stack_index > stacks_i) ? stacks_i : in_i.stack_index;
    item.slice = (in_i.slice_index > slices_i) ? slices_i : in_i.slice_index;
    item.quad  = (item.stack < stacks_i) && (item.slice < slices_i);
  end

  assign in_i.ready   = (count_q != (PTR_W+1)'(DEPTH));
  assign push         = in_i.valid && in_i.ready;
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/uvs_div.sv
// pipelined restoring divider, one quotient bit per stage
module uvs_div #(
  parameter int unsigned NW = 44,
  parameter int unsigned DW = 12
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_q  [NW];
  logic [NW-1:0] nq_q   [NW];
  logic [DW-1:0] rem_in [NW+1];
  logic [NW-1:0] nq_in  [NW+1];

  assign rem_in[0] = '0;
  assign nq_in[0]  = num_i;

  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] trial;
    logic        ge;
    always_comb begin
      trial = {rem_in[k], nq_in[k][NW-1]};
      ge    = (trial >= {1'b0, den_i});
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
        nq_q[k]  <= {nq_in[k][NW-2:0], ge};
      end
    end
    assign rem_in[k+1] = rem_q[k];
    assign nq_in[k+1]  = nq_q[k];
  end

  assign quo_o = nq_in[NW];

endmodule

>>> rtl/core/uvs_cordic.sv
// pipelined rotation cordic giving cosine and sine of a phase in turns
module uvs_cordic #(
  parameter int unsigned STEPS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  localparam int unsigned XW = 34;
  localparam logic signed [XW-1:0] ONE = 34'sd1073741824;
  localparam logic signed [XW-1:0] CORDIC_X0_S = {2'b00, uvs_pkg::CORDIC_X0};

  logic signed [XW-1:0] x_q [STEPS+1];
  logic signed [XW-1:0] y_q [STEPS+1];
  logic signed [XW-1:0] z_q [STEPS+1];
  logic [1:0]           q_q [STEPS+1];
  logic [31:0]          sum;
  logic [1:0]           quad;
  logic [31:0]          resid;
  logic signed [31:0]   cr, sr;
  logic signed [31:0]   cos_q, sin_q;

  function automatic logic signed [31:0] clamp_unit(input logic signed [XW-1:0] v);
    if (v > ONE) begin
      return 32'sd1073741824;
    end else if (v < -ONE) begin
      return -32'sd1073741824;
    end
    return v[31:0];
  endfunction

  always_comb begin
    sum   = phase_i + 32'h20000000;
    quad  = sum[31:30];
    resid = phase_i - {quad, 30'd0};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= CORDIC_X0_S;
      y_q[0] <= '0;
      z_q[0] <= {{(XW-32){resid[31]}}, resid};
      q_q[0] <= quad;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [XW-1:0] dx, dy, at;
    always_comb begin
      dx = y_q[i] >>> i;
      dy = x_q[i] >>> i;
      at = {2'b00, uvs_pkg::ATAN_TURNS[i]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][XW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        q_q[i+1] <= q_q[i];
      end
    end
  end

  always_comb begin
    cr = clamp_unit(x_q[STEPS]);
    sr = clamp_unit(y_q[STEPS]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (q_q[STEPS])
        2'd0: begin
          cos_q <= cr;
          sin_q <= sr;
        end
        2'd1: begin
          cos_q <= -sr;
          sin_q <= cr;
        end
        2'd2: begin
          cos_q <= -cr;
          sin_q <= -sr;
        end
        default: begin
          cos_q <= sr;
          sin_q <= -cr;
        end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

>>> rtl/core/uvs_back.sv
// back end: dividers, cordic units, scaling and the output register
module uvs_back #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  uvs_pkg::queue_t head_i,
  output logic            pop_o,
  input  uvs_pkg::cfg_t   cfg_i,
  uvs_out_if.source       out_o
);

  localparam int unsigned NW = 44;
  localparam int unsigned DW = 12;
  localparam int unsigned CL = CORDIC_STEPS + 2;

  typedef struct packed {
    logic [20:0] vnum;
    logic        quad;
  } side_t;

  typedef struct packed {
    logic [20:0] vnum;
    logic        quad;
    logic [14:0] tex_s;
    logic [14:0] tex_t;
    logic [63:0] color;
  } attr_t;

  logic adv;

  // stage b0
  logic          b0_v_q;
  logic [NW-1:0] num_a_q, num_b_q;
  logic [26:0]   num_c_q [4];
  side_t         b0_sd_q;
  logic [22:0]   vnum_full;

  // divider section
  logic [NW-1:0] quo_a, quo_b;
  logic [NW-1:0] quo_c [4];
  logic [NW-1:0] v_div_q;
  side_t         sd_div_q [NW];

  // cordic section
  logic [31:0]        pha, phb;
  logic [33:0]        tsa;
  logic [32:0]        tsb;
  attr_t              attr;
  logic [CL-1:0]      v_cor_q;
  attr_t              at_cor_q [CL];
  logic signed [31:0] ca, sa, cb, sb;

  // scaling stages
  logic               p1_v_q, p2_v_q, p3_v_q;
  attr_t              p1_at_q, p2_at_q, p3_at_q;
  logic signed [63:0] rcb_q, rsb_q, ncx_q, ncz_q;
  logic signed [31:0] p1_ca_q, p1_sa_q, p2_ca_q, p2_sa_q;
  logic signed [15:0] p1_ny_q, p2_ny_q, p3_ny_q;
  logic signed [32:0] big_r_q;
  logic signed [31:0] p2_py_q, p3_py_q;
  logic signed [15:0] p2_nx_q, p2_nz_q, p3_nx_q, p3_nz_q;
  logic signed [64:0] pxp_q, pzp_q;
  logic signed [31:0] r_s, sb_rnd;
  logic signed [63:0] rcb_rnd, rsb_rnd, ncx_rnd, ncz_rnd;
  logic signed [64:0] pxp_rnd, pzp_rnd;

  // output register
  logic               out_valid_q;
  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [15:0] norm_x_q, norm_y_q, norm_z_q;
  attr_t              out_at_q;

  function automatic logic signed [31:0] clamp_pos(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sd2147483647;
    end else if (v < -36'sd2147483647) begin
      return -32'sd2147483647;
    end
    return v[31:0];
  endfunction

  assign adv   = !out_valid_q || out_o.ready;
  assign pop_o = adv && head_i.valid;

  assign vnum_full = 23'(12'({1'b0, cfg_i.slices} + 12'd1) * head_i.item.stack)
                     + 23'(head_i.item.slice);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num_a_q <= NW'({head_i.item.slice, 33'd0}) + NW'(cfg_i.slices);
      num_b_q <= NW'({head_i.item.stack, 32'd0}) + NW'(cfg_i.stacks);
      for (int k = 0; k < 4; k++) begin
        num_c_q[k] <= 27'(cfg_i.south[16*k +: 16]) * 27'(cfg_i.stacks - head_i.item.stack)
                      + 27'(cfg_i.north[16*k +: 16]) * 27'(head_i.item.stack)
                      + 27'(cfg_i.stacks >> 1);
      end
      b0_sd_q.vnum <= vnum_full[20:0];
      b0_sd_q.quad <= head_i.item.quad;
    end
  end

  uvs_div #(.NW(NW), .DW(DW)) u_div_a (
    .clk_i (clk_i), .en_i (adv), .num_i (num_a_q),
    .den_i ({cfg_i.slices, 1'b0}), .quo_o (quo_a)
  );

  uvs_div #(.NW(NW), .DW(DW)) u_div_b (
    .clk_i (clk_i), .en_i (adv), .num_i (num_b_q),
    .den_i ({cfg_i.stacks, 1'b0}), .quo_o (quo_b)
  );

  for (genvar k = 0; k < 4; k++) begin : g_color
    uvs_div #(.NW(NW), .DW(DW)) u_div_c (
      .clk_i (clk_i), .en_i (adv), .num_i (NW'(num_c_q[k])),
      .den_i ({1'b0, cfg_i.stacks}), .quo_o (quo_c[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_div_q[0] <= b0_sd_q;
      for (int k = 1; k < NW; k++) begin
        sd_div_q[k] <= sd_div_q[k-1];
      end
    end
  end

  always_comb begin
    pha        = quo_a[31:0];
    phb        = quo_b[31:0] - 32'h40000000;
    tsa        = 34'(quo_a[32:0]) + 34'h20000;
    tsb        = 33'(quo_b[31:0]) + 33'h10000;
    attr.vnum  = sd_div_q[NW-1].vnum;
    attr.quad  = sd_div_q[NW-1].quad;
    attr.tex_s = 15'd4096 + 15'(tsa[33:18]);
    attr.tex_t = 15'd16384 - 15'(tsb[32:17]);
    attr.color = {quo_c[3][15:0], quo_c[2][15:0], quo_c[1][15:0], quo_c[0][15:0]};
  end

  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_a (
    .clk_i (clk_i), .en_i (adv), .phase_i (pha), .cos_o (ca), .sin_o (sa)
  );

  uvs_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_b (
    .clk_i (clk_i), .en_i (adv), .phase_i (phb), .cos_o (cb), .sin_o (sb)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      at_cor_q[0] <= attr;
      for (int k = 1; k < CL; k++) begin
        at_cor_q[k] <= at_cor_q[k-1];
      end
    end
  end

  always_comb begin
    r_s     = {1'b0, cfg_i.radius};
    sb_rnd  = sb + 32'sh8000;
    rcb_rnd = rcb_q + 64'sh20000000;
    rsb_rnd = rsb_q + 64'sh20000000;
    ncx_rnd = ncx_q + 64'sh200000000000;
    ncz_rnd = ncz_q + 64'sh200000000000;
    pxp_rnd = pxp_q + 65'sh20000000;
    pzp_rnd = pzp_q + 65'sh20000000;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rcb_q    <= r_s * cb;
      rsb_q    <= r_s * sb;
      ncx_q    <= cb * ca;
      ncz_q    <= cb * sa;
      p1_ca_q  <= ca;
      p1_sa_q  <= sa;
      p1_ny_q  <= sb_rnd[31:16];
      p1_at_q  <= at_cor_q[CL-1];

      big_r_q  <= 33'(rcb_rnd >>> 30);
      p2_py_q  <= clamp_pos(36'(rsb_rnd >>> 30));
      p2_nx_q  <= 16'(ncx_rnd >>> 46);
      p2_nz_q  <= 16'(ncz_rnd >>> 46);
      p2_ca_q  <= p1_ca_q;
      p2_sa_q  <= p1_sa_q;
      p2_ny_q  <= p1_ny_q;
      p2_at_q  <= p1_at_q;

      pxp_q    <= big_r_q * p2_ca_q;
      pzp_q    <= big_r_q * p2_sa_q;
      p3_py_q  <= p2_py_q;
      p3_nx_q  <= p2_nx_q;
      p3_nz_q  <= p2_nz_q;
      p3_ny_q  <= p2_ny_q;
      p3_at_q  <= p2_at_q;

      pos_x_q  <= clamp_pos(36'(pxp_rnd >>> 30));
      pos_z_q  <= clamp_pos(36'(pzp_rnd >>> 30));
      pos_y_q  <= p3_py_q;
      norm_x_q <= p3_nx_q;
      norm_y_q <= p3_ny_q;
      norm_z_q <= p3_nz_q;
      out_at_q <= p3_at_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q      <= 1'b0;
      v_div_q     <= '0;
      v_cor_q     <= '0;
      p1_v_q      <= 1'b0;
      p2_v_q      <= 1'b0;
      p3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      b0_v_q      <= pop_o;
      v_div_q     <= {v_div_q[NW-2:0], b0_v_q};
      v_cor_q     <= {v_cor_q[CL-2:0], v_div_q[NW-1]};
      p1_v_q      <= v_cor_q[CL-1];
      p2_v_q      <= p1_v_q;
      p3_v_q      <= p2_v_q;
      out_valid_q <= p3_v_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pos_x         = pos_x_q;
  assign out_o.pos_y         = pos_y_q;
  assign out_o.pos_z         = pos_z_q;
  assign out_o.norm_x        = norm_x_q;
  assign out_o.norm_y        = norm_y_q;
  assign out_o.norm_z        = norm_z_q;
  assign out_o.tex_s         = out_at_q.tex_s;
  assign out_o.tex_t         = out_at_q.tex_t;
  assign out_o.blend_color   = out_at_q.color;
  assign out_o.vertex_number = out_at_q.vnum;
  assign out_o.quad_valid    = out_at_q.quad;

endmodule

>>> rtl/core/uv_sphere_vertex_generator.sv
// top level of the uv sphere vertex generator
// throughput: one vertex per cycle while the output is not stalled,
// set by the fully pipelined dividers and cordic units
// a four-entry queue between front and back absorbs output stalls
// reset: asynchronous active low, clears control state and loads register defaults
module uv_sphere_vertex_generator #(
  parameter int unsigned MAX_SLICES   = 1024,
  parameter int unsigned MAX_STACKS   = 1024,
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  uvs_in_if.sink                            in_i,
  uvs_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [63:0]                       cfg_data_i
);

  localparam logic [12:0] MAX_SL = 13'(MAX_SLICES);
  localparam logic [12:0] MAX_ST = 13'(MAX_STACKS);

  logic [uvs_pkg::RADIUS_W-1:0] radius_q;
  logic [uvs_pkg::CNT_W-1:0]    slice_cnt_q, stack_cnt_q;
  logic [63:0]                  north_q, south_q;
  logic [uvs_pkg::CNT_W-1:0]    slices, stacks;
  uvs_pkg::cfg_t                cfg;
  uvs_pkg::queue_t              head;
  logic                         pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q    <= 31'd65536;
      slice_cnt_q <= 11'd16;
      stack_cnt_q <= 11'd16;
      north_q     <= 64'h8000800080008000;
      south_q     <= 64'h8000800080008000;
    end else if (cfg_we_i) begin
      case (uvs_pkg::cfg_reg_e'(cfg_idx_i))
        uvs_pkg::REG_RADIUS:      radius_q    <= cfg_data_i[30:0];
        uvs_pkg::REG_SLICE_COUNT: slice_cnt_q <= cfg_data_i[10:0];
        uvs_pkg::REG_STACK_COUNT: stack_cnt_q <= cfg_data_i[10:0];
        uvs_pkg::REG_NORTH_COLOR: north_q     <= cfg_data_i;
        uvs_pkg::REG_SOUTH_COLOR: south_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (slice_cnt_q == '0) begin
      slices = 11'd1;
    end else if ({2'b00, slice_cnt_q} > MAX_SL) begin
      slices = MAX_SL[10:0];
    end else begin
      slices = slice_cnt_q;
    end
    if (stack_cnt_q == '0) begin
      stacks = 11'd1;
    end else if ({2'b00, stack_cnt_q} > MAX_ST) begin
      stacks = MAX_ST[10:0];
    end else begin
      stacks = stack_cnt_q;
    end
    cfg.radius = radius_q;
    cfg.slices = slices;
    cfg.stacks = stacks;
    cfg.north  = north_q;
    cfg.south  = south_q;
  end

  uvs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .slices_i (slices),
    .stacks_i (stacks),
    .head_o   (head),
    .pop_i    (pop)
  );

  uvs_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .cfg_i  (cfg),
    .out_o  (out_o)
  );

`ifndef ASSERT_OFF
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> head.valid)
    else $error("queue full but empty");

  a_quad_tex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.quad_valid) |-> (out_o.tex_s < 15'd20480 && out_o.tex_t != 15'd0))
    else $error("quad at last row or column");

  a_norm_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.norm_y <= 16'sd16384 && out_o.norm_y >= -16'sd16384))
    else $error("normal y out of range");
`endif

endmodule

>>> bench/uvs_tb_if.sv
// the testbench drives the block through the channel interfaces of the rtl

>>> bench/uv_sphere_vertex_generator_tb.sv
// testbench of the uv sphere vertex generator: predicts every vertex and checks each result
module uv_sphere_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_MAX_SLICES = 1024;
  localparam int unsigned N_MAX_STACKS = 1024;
  localparam int unsigned N_STEPS      = 16;
  localparam int unsigned PIPE_DRAIN   = 120;
  localparam logic [uvs_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;
    logic [14:0]        tex_s;
    logic [14:0]        tex_t;
    logic [63:0]        color;
    logic [20:0]        vnum;
    logic               quad;
  } vertex_t;

  class vertex_scoreboard;
    vertex_t pending[$];
    int      mismatches;
    logic [30:0] radius;
    logic [10:0] slices_reg;
    logic [10:0] stacks_reg;
    logic [63:0] north;
    logic [63:0] south;

    function new();
      mismatches = 0;
      radius = 31'd65536;
      slices_reg = 11'd16;
      stacks_reg = 11'd16;
      north = 64'h8000800080008000;
      south = 64'h8000800080008000;
    endfunction

    function void write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
      case (uvs_pkg::cfg_reg_e'(idx))
        uvs_pkg::REG_RADIUS:      radius = data[30:0];
        uvs_pkg::REG_SLICE_COUNT: slices_reg = data[10:0];
        uvs_pkg::REG_STACK_COUNT: stacks_reg = data[10:0];
        uvs_pkg::REG_NORTH_COLOR: north = data;
        uvs_pkg::REG_SOUTH_COLOR: south = data;
        default: ;
      endcase
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint rshift(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function longint unit_clamp(longint v);
      if (v > 64'sd1073741824) return 64'sd1073741824;
      if (v < -64'sd1073741824) return -64'sd1073741824;
      return v;
    endfunction

    function longint pos_clamp(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483647) return -64'sd2147483647;
      return v;
    endfunction

    task automatic cordic(input logic [31:0] phase, output longint c, output longint s);
      logic [1:0]  q;
      logic [31:0] r32;
      longint      z, x, y, dx, dy, cr, sr;
      q = 2'((phase + 32'h20000000) >> 30);
      r32 = phase - {q, 30'd0};
      z = longint'($signed(r32));
      x = longint'(uvs_pkg::CORDIC_X0);
      y = 0;
      for (int i = 0; i < N_STEPS; i++) begin
        dx = fshift(y, i);
        dy = fshift(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(uvs_pkg::ATAN_TURNS[i]);
        end else begin
          x += dx; y -= dy; z += longint'(uvs_pkg::ATAN_TURNS[i]);
        end
      end
      cr = unit_clamp(x);
      sr = unit_clamp(y);
      case (q)
        2'd0: begin c = cr; s = sr; end
        2'd1: begin c = -sr; s = cr; end
        2'd2: begin c = -cr; s = -sr; end
        default: begin c = sr; s = -cr; end
      endcase
    endtask

    task automatic note_vertex(input logic [10:0] stack_in, input logic [10:0] slice_in);
      longint unsigned slices, stacks, stk, slc, nc, sc, v;
      logic [31:0] pha, phb;
      longint      ca, sa, cb, sb, r, big_r;
      vertex_t     e;
      slices = 64'(slices_reg);
      stacks = 64'(stacks_reg);
      stk = 64'(stack_in);
      slc = 64'(slice_in);
      if (slices < 1) slices = 1;
      if (slices > N_MAX_SLICES) slices = N_MAX_SLICES;
      if (stacks < 1) stacks = 1;
      if (stacks > N_MAX_STACKS) stacks = N_MAX_STACKS;
      if (stk > stacks) stk = stacks;
      if (slc > slices) slc = slices;
      pha = 32'(((slc << 33) + slices) / (2 * slices));
      phb = 32'((((stk << 32) + stacks) / (2 * stacks)) - 64'h40000000);
      cordic(pha, ca, sa);
      cordic(phb, cb, sb);
      r = longint'(radius);
      big_r = rshift(r * cb, 30);
      e.pos_x = 32'(pos_clamp(rshift(big_r * ca, 30)));
      e.pos_y = 32'(pos_clamp(rshift(r * sb, 30)));
      e.pos_z = 32'(pos_clamp(rshift(big_r * sa, 30)));
      e.norm_x = 16'(rshift(cb * ca, 46));
      e.norm_y = 16'(rshift(sb, 16));
      e.norm_z = 16'(rshift(cb * sa, 46));
      e.tex_s = 15'(4096 + (slc * 32768 + slices) / (2 * slices));
      e.tex_t = 15'(16384 - (stk * 32768 + stacks) / (2 * stacks));
      for (int k = 0; k < 4; k++) begin
        nc = (north >> (16 * k)) & 64'hFFFF;
        sc = (south >> (16 * k)) & 64'hFFFF;
        v = (sc * (stacks - stk) + nc * stk + stacks / 2) / stacks;
        e.color[16*k +: 16] = v[15:0];
      end
      e.vnum = 21'((slices + 1) * stk + slc);
      e.quad = (stk < stacks && slc < slices);
      pending = {pending, e};
    endtask

    function void check_vertex(vertex_t got);
      vertex_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch pos %h %h %h / %h %h %h", e.pos_x, e.pos_y, e.pos_z,
                   got.pos_x, got.pos_y, got.pos_z);
          $display("  norm %h %h %h / %h %h %h", e.norm_x, e.norm_y, e.norm_z,
                   got.norm_x, got.norm_y, got.norm_z);
          $display("  tex %h %h / %h %h color %h / %h", e.tex_s, e.tex_t, got.tex_s,
                   got.tex_t, e.color, got.color);
          $display("  vnum %h %b / %h %b", e.vnum, e.quad, got.vnum, got.quad);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [uvs_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [63:0] cfg_data_i;
  uvs_in_if    in_ch();
  uvs_out_if   out_ch();
  vertex_scoreboard board;

  uv_sphere_vertex_generator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(logic [uvs_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    board.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_vertex(logic [10:0] stk, logic [10:0] slc, bit burst);
    int g;
    g = burst ? 0 : gap_len();
    repeat (g) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.stack_index <= stk;
    in_ch.slice_index <= slc;
    do @(posedge clk_i); while (!in_ch.ready);
    board.note_vertex(stk, slc);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (PIPE_DRAIN) @(negedge clk_i);
  endtask

  function automatic logic [10:0] pick_index(logic [10:0] cnt);
    int p;
    p = $urandom_range(0, 19);
    if (p == 0) return 11'($urandom_range(0, 2047));
    if (p == 1) return cnt;
    if (p == 2) return 11'd0;
    return 11'($urandom_range(0, cnt));
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready)
        board.check_vertex({out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.norm_x,
                            out_ch.norm_y, out_ch.norm_z, out_ch.tex_s, out_ch.tex_t,
                            out_ch.blend_color, out_ch.vertex_number, out_ch.quad_valid});
    end
  end

  initial begin
    int g;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) g = 0;
      else g = gap_len();
      if (g == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        repeat (g) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #60ms;
    $display("[uv_sphere_vertex_generator] ERROR");
    $finish;
  end

  initial begin
    logic [10:0] sl, st;
    int count;
    board = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.stack_index = '0;
    in_ch.slice_index = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed corners with reset values
    send_vertex(11'd0, 11'd0, 1'b0);
    send_vertex(11'd16, 11'd16, 1'b0);
    send_vertex(11'd8, 11'd4, 1'b0);
    send_vertex(11'd2047, 11'd2047, 1'b0);
    send_vertex(11'h555, 11'h2AA, 1'b0);
    send_vertex(11'h2AA, 11'h555, 1'b0);
    send_vertex(11'd3, 11'd13, 1'b1);
    settle();
    write_reg(uvs_pkg::REG_RADIUS, 64'h7FFF_FFFF);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 64'd1024);
    write_reg(uvs_pkg::REG_STACK_COUNT, 64'd1024);
    write_reg(uvs_pkg::REG_NORTH_COLOR, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(uvs_pkg::REG_SOUTH_COLOR, 64'h0);
    send_vertex(11'd0, 11'd0, 1'b0);
    send_vertex(11'd1024, 11'd1024, 1'b0);
    send_vertex(11'd512, 11'd256, 1'b0);
    send_vertex(11'd1023, 11'd1023, 1'b0);
    send_vertex(11'h7FF, 11'h400, 1'b0);
    settle();
    write_reg(uvs_pkg::REG_RADIUS, 64'd0);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 64'd0);
    write_reg(uvs_pkg::REG_STACK_COUNT, 64'h7FF);
    send_vertex(11'd5, 11'd1, 1'b0);
    send_vertex(11'd0, 11'd7, 1'b0);
    send_vertex(11'd1024, 11'd0, 1'b0);
    settle();
    write_reg(uvs_pkg::REG_RADIUS, 64'h1);
    write_reg(uvs_pkg::REG_SLICE_COUNT, 64'd1);
    write_reg(uvs_pkg::REG_STACK_COUNT, 64'd1);
    write_reg(REG_NONE, 64'hDEAD);
    send_vertex(11'd0, 11'd0, 1'b0);
    send_vertex(11'd1, 11'd1, 1'b0);
    send_vertex(11'd0, 11'd1, 1'b0);
    settle();

    for (int ph = 0; ph < 11; ph++) begin
      write_reg(uvs_pkg::REG_RADIUS,
                ph == 0 ? 64'h7FFF_FFFF : 64'($urandom_range(0, 32'h7FFF_FFFF)));
      sl = (ph % 3 == 0) ? 11'($urandom_range(1, 20)) : 11'($urandom_range(0, 2047));
      st = (ph % 4 == 0) ? 11'($urandom_range(1, 20)) : 11'($urandom_range(0, 2047));
      write_reg(uvs_pkg::REG_SLICE_COUNT, {53'd0, sl});
      write_reg(uvs_pkg::REG_STACK_COUNT, {53'd0, st});
      write_reg(uvs_pkg::REG_NORTH_COLOR, {$urandom, $urandom});
      write_reg(uvs_pkg::REG_SOUTH_COLOR, {$urandom, $urandom});
      if (sl == 0) sl = 11'd1;
      if (sl > 1024) sl = 11'd1024;
      if (st == 0) st = 11'd1;
      if (st > 1024) st = 11'd1024;
      count = 150;
      for (int n = 0; n < count; n++)
        send_vertex(pick_index(st), pick_index(sl), $urandom_range(0, 3) == 0);
      settle();
    end
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("[uv_sphere_vertex_generator] OK");
    else
      $display("[uv_sphere_vertex_generator] ERROR");
    $finish;
  end
endmodule
